/* rtl/cif_pkg.sv */
// Package with the transaction types and status codes of the collision force core.
package cif_pkg;

  typedef struct packed {
    logic signed [31:0] velocity_one;
    logic signed [31:0] velocity_two;
    logic [30:0]        mass_one;
    logic [30:0]        mass_two;
    logic signed [31:0] push_one;
    logic signed [31:0] push_two;
    logic               fixed_one;
    logic               fixed_two;
    logic [17:0]        restitution;
    logic [30:0]        step_time;
  } item_t;

  typedef struct packed {
    logic signed [31:0] force_one;
    logic signed [31:0] force_two;
    logic [1:0]         status;
  } result_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DIV0 = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

endpackage

/* rtl/collision_impulse_force_core.sv */
// Pipelined one-axis collision force core with restitution and saturation.
// Throughput: one transaction per cycle unless result_stall holds the
// pipeline; the reduced-mass divider (31 stages) and the two force
// dividers (32 stages each) retire one quotient bit per stage.
// The whole pipeline holds while a result waits under stall.
// Reset clears all valid bits; data registers are not reset.
module collision_impulse_force_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  cif_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output cif_pkg::result_t result
);

  localparam int EPW = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 1;
  localparam int SW  = 32 + EPW;
  localparam int DVW = 32 + EPW - FRAC_BITS;
  localparam int PW  = 32 + DVW;
  localparam int HW  = DVW - 32;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic [EPW-1:0] ONE = EPW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [30:0]    t;
    logic           zero_t;
    logic           div0;
    logic           pair;
    logic           neg1;
    logic           neg2;
    logic [30:0]    m1;
    logic [30:0]    m2;
    logic [DVW-1:0] b1;
    logic [DVW-1:0] b2;
  } ctx_t;

  typedef struct packed {
    logic [30:0] t;
    logic        zero_t;
    logic        div0;
    logic        neg1;
    logic        neg2;
    logic        over1;
    logic        over2;
  } fctx_t;

  logic en;
  assign en = !result_valid || !result_stall;
  assign item_stall = !en;

  // Input register.
  logic           v0;
  cif_pkg::item_t it0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= item_valid;
    end
    if (en) begin
      it0 <= item;
    end
  end

  // Stage 1: sums, differences, magnitudes, mass product.
  logic           v1;
  cif_pkg::item_t it1;
  logic [32:0]    msum1;
  logic [61:0]    pm1;
  logic [31:0]    dmag1, av1_1, av2_1;
  logic           dpos1, dneg1;
  logic [EPW-1:0] ep1;
  logic signed [32:0] d_c;

  assign d_c = $signed({it0.velocity_one[31], it0.velocity_one})
             - $signed({it0.velocity_two[31], it0.velocity_two});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      it1   <= it0;
      msum1 <= 33'(it0.mass_one) + 33'(it0.mass_two);
      pm1   <= 62'(it0.mass_one) * 62'(it0.mass_two);
      dmag1 <= d_c[32] ? 32'(-d_c) : d_c[31:0];
      dpos1 <= !d_c[32] && (d_c != '0);
      dneg1 <= d_c[32];
      av1_1 <= it0.velocity_one[31] ? 32'(-it0.velocity_one) : it0.velocity_one;
      av2_1 <= it0.velocity_two[31] ? 32'(-it0.velocity_two) : it0.velocity_two;
      ep1   <= ONE + EPW'(it0.restitution);
    end
  end

  // Stage 2: restitution scaling products and rounded reduced-mass numerator.
  logic           v2;
  cif_pkg::item_t it2;
  logic [32:0]    msum2;
  logic [62:0]    nh2;
  logic [SW-1:0]  sd2, sa1_2, sa2_2;
  logic [31:0]    av1_2, av2_2;
  logic           dpos2, dneg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      it2   <= it1;
      msum2 <= msum1;
      nh2   <= 63'(pm1) + 63'(msum1[32:1]);
      sd2   <= SW'(dmag1) * SW'(ep1);
      sa1_2 <= SW'(av1_1) * SW'(ep1);
      sa2_2 <= SW'(av2_1) * SW'(ep1);
      av1_2 <= av1_1;
      av2_2 <= av2_1;
      dpos2 <= dpos1;
      dneg2 <= dneg1;
    end
  end

  // Stage 3: case selection, then the reduced-mass divider.
  logic [DVW-1:0] dv_c, dv1_c, dv2_c;
  logic           same1, same2, slow1, slow2;
  ctx_t           ctx_c;

  assign dv_c  = DVW'((sd2 + HALF) >> FRAC_BITS);
  assign dv1_c = DVW'((sa1_2 + HALF) >> FRAC_BITS);
  assign dv2_c = DVW'((sa2_2 + HALF) >> FRAC_BITS);
  assign same1 = (it2.velocity_one > 0 && it2.push_one > 0)
              || (it2.velocity_one < 0 && it2.push_one < 0);
  assign same2 = (it2.velocity_two > 0 && it2.push_two > 0)
              || (it2.velocity_two < 0 && it2.push_two < 0);
  assign slow1 = {av1_2, 1'b0} < 33'(it2.restitution);
  assign slow2 = {av2_2, 1'b0} < 33'(it2.restitution);

  always_comb begin
    ctx_c.t      = it2.step_time;
    ctx_c.zero_t = (it2.step_time == '0);
    ctx_c.pair   = !it2.fixed_one && !it2.fixed_two;
    ctx_c.div0   = ctx_c.pair && (msum2 == '0);
    ctx_c.m1     = it2.mass_one;
    ctx_c.m2     = it2.mass_two;
    if (ctx_c.pair) begin
      ctx_c.neg1 = dpos2;
      ctx_c.neg2 = dneg2;
      ctx_c.b1   = dv_c;
      ctx_c.b2   = dv_c;
    end else begin
      ctx_c.neg1 = it2.velocity_one > 0;
      ctx_c.neg2 = it2.velocity_two > 0;
      ctx_c.b1   = (it2.fixed_one || (same1 && slow1)) ? DVW'(av1_2) : dv1_c;
      ctx_c.b2   = (it2.fixed_two || (same2 && slow2)) ? DVW'(av2_2) : dv2_c;
    end
  end

  logic        hv   [32];
  ctx_t        hctx [32];
  logic [32:0] hrem [32];
  logic [30:0] hq   [32];
  logic [62:0] hnum [32];
  logic [32:0] hdiv [32];

  always_ff @(posedge clk) begin
    if (rst) begin
      hv[0] <= 1'b0;
    end else if (en) begin
      hv[0] <= v2;
    end
    if (en) begin
      hctx[0] <= ctx_c;
      hrem[0] <= {1'b0, nh2[62:31]};
      hq[0]   <= '0;
      hnum[0] <= nh2;
      hdiv[0] <= msum2;
    end
  end

  for (genvar k = 0; k < 31; k++) begin : g_hdiv
    logic [33:0] trial;
    logic        ge;
    assign trial = {hrem[k], hnum[k][30-k]};
    assign ge    = trial >= {1'b0, hdiv[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        hv[k+1] <= 1'b0;
      end else if (en) begin
        hv[k+1] <= hv[k];
      end
      if (en) begin
        hctx[k+1] <= hctx[k];
        hrem[k+1] <= ge ? 33'(trial - {1'b0, hdiv[k]}) : trial[32:0];
        hq[k+1]   <= {hq[k][29:0], ge};
        hnum[k+1] <= hnum[k];
        hdiv[k+1] <= hdiv[k];
      end
    end
  end

  // Stage 4: operand selection.
  logic           v4;
  ctx_t           ctx4;
  logic [30:0]    a1_4, a2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= hv[31];
    end
    if (en) begin
      ctx4 <= hctx[31];
      a1_4 <= hctx[31].pair ? hq[31] : hctx[31].m1;
      a2_4 <= hctx[31].pair ? hq[31] : hctx[31].m2;
    end
  end

  // Stage 5: partial products.
  logic           v5;
  ctx_t           ctx5;
  logic [62:0]    pl1, pl2;
  logic [30+HW:0] ph1, ph2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      ctx5 <= ctx4;
      pl1  <= 63'(a1_4) * 63'(ctx4.b1[31:0]);
      pl2  <= 63'(a2_4) * 63'(ctx4.b2[31:0]);
      ph1  <= (31+HW)'(a1_4) * (31+HW)'(ctx4.b1[DVW-1:32]);
      ph2  <= (31+HW)'(a2_4) * (31+HW)'(ctx4.b2[DVW-1:32]);
    end
  end

  // Stage 6: full products plus rounding offset.
  logic          v6;
  ctx_t          ctx6;
  logic [PW-1:0] n1, n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      ctx6 <= ctx5;
      n1   <= PW'(pl1) + (PW'(ph1) << 32) + PW'(ctx5.t[30:1]);
      n2   <= PW'(pl2) + (PW'(ph2) << 32) + PW'(ctx5.t[30:1]);
    end
  end

  // Stage 7 onward: overflow check, then the two force dividers.
  fctx_t fctx_c;

  always_comb begin
    fctx_c.t      = ctx6.t;
    fctx_c.zero_t = ctx6.zero_t;
    fctx_c.div0   = ctx6.div0;
    fctx_c.neg1   = ctx6.neg1;
    fctx_c.neg2   = ctx6.neg2;
    fctx_c.over1  = n1[PW-1:32] >= DVW'(ctx6.t);
    fctx_c.over2  = n2[PW-1:32] >= DVW'(ctx6.t);
  end

  logic        fv   [33];
  fctx_t       fctx [33];
  logic [30:0] frem1 [33];
  logic [30:0] frem2 [33];
  logic [31:0] fq1  [33];
  logic [31:0] fq2  [33];
  logic [31:0] fn1  [33];
  logic [31:0] fn2  [33];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv[0] <= 1'b0;
    end else if (en) begin
      fv[0] <= v6;
    end
    if (en) begin
      fctx[0]  <= fctx_c;
      frem1[0] <= n1[62:32];
      frem2[0] <= n2[62:32];
      fq1[0]   <= '0;
      fq2[0]   <= '0;
      fn1[0]   <= n1[31:0];
      fn2[0]   <= n2[31:0];
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_fdiv
    logic [31:0] trial1, trial2;
    logic        ge1, ge2;
    assign trial1 = {frem1[k], fn1[k][31-k]};
    assign trial2 = {frem2[k], fn2[k][31-k]};
    assign ge1    = trial1 >= {1'b0, fctx[k].t};
    assign ge2    = trial2 >= {1'b0, fctx[k].t};
    always_ff @(posedge clk) begin
      if (rst) begin
        fv[k+1] <= 1'b0;
      end else if (en) begin
        fv[k+1] <= fv[k];
      end
      if (en) begin
        fctx[k+1]  <= fctx[k];
        frem1[k+1] <= ge1 ? 31'(trial1 - {1'b0, fctx[k].t}) : trial1[30:0];
        frem2[k+1] <= ge2 ? 31'(trial2 - {1'b0, fctx[k].t}) : trial2[30:0];
        fq1[k+1]   <= {fq1[k][30:0], ge1};
        fq2[k+1]   <= {fq2[k][30:0], ge2};
        fn1[k+1]   <= fn1[k];
        fn2[k+1]   <= fn2[k];
      end
    end
  end

  // Output stage: clamp, sign and status.
  fctx_t       fx;
  logic        sat1, sat2;
  logic [31:0] cap1, cap2, mag1, mag2;
  cif_pkg::result_t res_c;

  assign fx   = fctx[32];
  assign cap1 = fx.neg1 ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign cap2 = fx.neg2 ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign sat1 = fx.over1 || (fq1[32] > cap1);
  assign sat2 = fx.over2 || (fq2[32] > cap2);
  assign mag1 = sat1 ? cap1 : fq1[32];
  assign mag2 = sat2 ? cap2 : fq2[32];

  always_comb begin
    if (fx.zero_t || fx.div0) begin
      res_c.force_one = '0;
      res_c.force_two = '0;
      res_c.status    = cif_pkg::STATUS_DIV0;
    end else begin
      res_c.force_one = fx.neg1 ? -mag1 : mag1;
      res_c.force_two = fx.neg2 ? -mag2 : mag2;
      res_c.status    = (sat1 || sat2) ? cif_pkg::STATUS_SAT : cif_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= fv[32];
    end
    if (en) begin
      result <= res_c;
    end
  end

  // A result's status never takes the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == cif_pkg::STATUS_OK
                   || result.status == cif_pkg::STATUS_DIV0
                   || result.status == cif_pkg::STATUS_SAT))
    else $error("result status has an unused code");

  // A zero divisor forces both results to zero.
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == cif_pkg::STATUS_DIV0)
      |-> (result.force_one == '0 && result.force_two == '0))
    else $error("zero divisor with nonzero force");

  // A saturated result carries at least one clamped force.
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == cif_pkg::STATUS_SAT)
      |-> (result.force_one == 32'h7FFF_FFFF || result.force_one == 32'h8000_0000
        || result.force_two == 32'h7FFF_FFFF || result.force_two == 32'h8000_0000))
    else $error("saturated status without a clamped force");

  // The pipeline holds while the output is stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> item_stall)
    else $error("pipeline advanced under output stall");

endmodule

/* tb/tb.sv */
// Testbench for the collision force core: directed, random, backpressure and streaming tests.
`timescale 1ns / 100ps

module tb;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY = 72;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  cif_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  cif_pkg::result_t result;

  cif_pkg::result_t expected_forces[$];
  int errors = 0;
  int sent_count = 0;
  int checked_count = 0;
  int idle_cycles = 0;
  bit idle_en = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;

  collision_impulse_force_core #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] scale_bounce(input logic [63:0] v, input logic [63:0] ep);
    return (v * ep + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  endfunction

  // Rounded a*b/t, clamped to the signed 32-bit range for the given sign.
  function automatic logic [31:0] force_of(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] t, input bit neg,
                                           inout bit sat);
    logic [127:0] q;
    logic [127:0] cap;
    cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    q = ({64'd0, a} * {64'd0, b} + {64'd0, t >> 1}) / {64'd0, t};
    if (q > cap) begin
      sat = 1'b1;
      q = cap;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic logic [31:0] wall_force(input longint v, input longint push,
                                             input logic [63:0] m, input logic [63:0] e,
                                             input logic [63:0] ep, input logic [63:0] t,
                                             inout bit sat);
    logic [63:0] av;
    logic [63:0] b;
    bit same;
    av = magnitude(v);
    same = (v > 0 && push > 0) || (v < 0 && push < 0);
    b = (same && 2 * av < e) ? av : scale_bounce(av, ep);
    return force_of(m, b, t, v > 0, sat);
  endfunction

  function automatic cif_pkg::result_t collision_force(input cif_pkg::item_t it);
    cif_pkg::result_t r;
    longint v1;
    longint v2;
    longint d;
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] msum;
    logic [63:0] h;
    logic [63:0] dv;
    logic [63:0] e;
    logic [63:0] ep;
    logic [63:0] t;
    bit sat;
    r = '0;
    sat = 1'b0;
    v1 = it.velocity_one;
    v2 = it.velocity_two;
    m1 = it.mass_one;
    m2 = it.mass_two;
    e = it.restitution;
    ep = (64'd1 << FRAC_BITS) + e;
    t = it.step_time;
    r.status = cif_pkg::STATUS_OK;
    if (t == 0) begin
      r.status = cif_pkg::STATUS_DIV0;
    end else if (!it.fixed_one && !it.fixed_two) begin
      msum = m1 + m2;
      if (msum == 0) begin
        r.status = cif_pkg::STATUS_DIV0;
      end else begin
        d = v1 - v2;
        h = (m1 * m2 + (msum >> 1)) / msum;
        dv = scale_bounce(magnitude(d), ep);
        r.force_one = force_of(h, dv, t, d > 0, sat);
        r.force_two = force_of(h, dv, t, d < 0, sat);
      end
    end else begin
      if (it.fixed_one) r.force_one = force_of(m1, magnitude(v1), t, v1 > 0, sat);
      else r.force_one = wall_force(v1, longint'(it.push_one), m1, e, ep, t, sat);
      if (it.fixed_two) r.force_two = force_of(m2, magnitude(v2), t, v2 > 0, sat);
      else r.force_two = wall_force(v2, longint'(it.push_two), m2, e, ep, t, sat);
    end
    if (r.status == cif_pkg::STATUS_OK && sat) r.status = cif_pkg::STATUS_SAT;
    return r;
  endfunction

  function automatic cif_pkg::item_t make_item(input logic [31:0] v1, input logic [31:0] v2,
                                               input logic [30:0] m1, input logic [30:0] m2,
                                               input logic [31:0] p1, input logic [31:0] p2,
                                               input bit s1, input bit s2,
                                               input logic [17:0] e, input logic [30:0] t);
    cif_pkg::item_t it;
    it.velocity_one = v1;
    it.velocity_two = v2;
    it.mass_one = m1;
    it.mass_two = m2;
    it.push_one = p1;
    it.push_two = p2;
    it.fixed_one = s1;
    it.fixed_two = s2;
    it.restitution = e;
    it.step_time = t;
    return it;
  endfunction

  function automatic logic [31:0] rand_velocity();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 2))
      0: v = {{15{v[31]}}, v[16:0]};
      1: v = {{8{v[31]}}, v[23:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rand_scalar();
    logic [30:0] x;
    x = 31'($urandom);
    case ($urandom_range(0, 3))
      0: x = x & 31'h0003_FFFF;
      1: x = x & 31'h00FF_FFFF;
      2: x = x & 31'h0FFF_FFFF;
      default: ;
    endcase
    return x;
  endfunction

  function automatic cif_pkg::item_t rand_item();
    cif_pkg::item_t it;
    it.velocity_one = rand_velocity();
    it.velocity_two = rand_velocity();
    it.mass_one = rand_scalar();
    it.mass_two = rand_scalar();
    it.push_one = $urandom;
    it.push_two = $urandom;
    it.fixed_one = $urandom_range(0, 2) == 0;
    it.fixed_two = $urandom_range(0, 2) == 0;
    it.restitution = ($urandom_range(0, 15) == 0) ? 18'd131072 : 18'($urandom_range(0, 131072));
    it.step_time = ($urandom_range(0, 40) == 0) ? 31'd0 : rand_scalar();
    if ($urandom_range(0, 30) == 0) begin
      it.mass_one = '0;
      it.mass_two = '0;
    end
    return it;
  endfunction

  task automatic send_item(input cif_pkg::item_t it);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    expected_forces.push_back(collision_force(it));
    sent_count++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(make_item(32'h0001_0000, 32'hFFFF_0000, 31'h1_0000, 31'h1_0000,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'h1_0000, 31'd0));
    send_item(make_item(32'h0001_0000, 32'hFFFF_0000, 31'd0, 31'd0,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'h8000, 31'h1_0000));
    send_item(make_item(32'h0002_0000, 32'hFFFE_0000, 31'h1_0000, 31'h3_0000,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'h1_0000, 31'h1_0000));
    send_item(make_item(32'hFFFE_0000, 32'h0002_0000, 31'h1_0000, 31'h3_0000,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'd0, 31'h1_0000));
    send_item(make_item(32'h0003_0000, 32'h0003_0000, 31'h2_0000, 31'h2_0000,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'd131072, 31'h8000));
    send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'd131072, 31'd1));
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'd131072, 31'd1));
    send_item(make_item(32'h0001_0000, 32'hFFFF_8000, 31'h2_0000, 31'h1_0000,
                        32'd0, 32'd0, 1'b1, 1'b1, 18'h8000, 31'h1_0000));
    send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'd0, 32'd0, 1'b1, 1'b1, 18'd0, 31'h7FFF_FFFF));
    send_item(make_item(32'h0000_1000, 32'h0001_0000, 31'h1_0000, 31'h1_0000,
                        32'h0001_0000, 32'd0, 1'b0, 1'b1, 18'h1_0000, 31'h1_0000));
    send_item(make_item(32'hFFFF_F000, 32'h0001_0000, 31'h1_0000, 31'h1_0000,
                        32'hFFFF_0000, 32'd0, 1'b0, 1'b1, 18'h1_0000, 31'h1_0000));
    send_item(make_item(32'h0000_1000, 32'h0001_0000, 31'h1_0000, 31'h1_0000,
                        32'hFFFF_0000, 32'd0, 1'b0, 1'b1, 18'h1_0000, 31'h1_0000));
    send_item(make_item(32'h0001_0000, 32'h0004_0000, 31'h1_0000, 31'h1_0000,
                        32'd0, 32'h0001_0000, 1'b1, 1'b0, 18'h1_0000, 31'h1_0000));
    send_item(make_item(32'h0001_0000, 32'hFFFF_F800, 31'h1_0000, 31'h1_0000,
                        32'd0, 32'h8000_0000, 1'b1, 1'b0, 18'h2_0000, 31'h1_0000));
    send_item(make_item(32'h0000_0800, 32'h0000_0000, 31'h1_0000, 31'h1_0000,
                        32'h7FFF_FFFF, 32'd0, 1'b0, 1'b1, 18'h1000, 31'h1_0000));
    send_item(make_item(32'h0000_0000, 32'h0000_0000, 31'h1_0000, 31'h1_0000,
                        32'h0001_0000, 32'hFFFF_0000, 1'b0, 1'b1, 18'h1_0000, 31'h1_0000));
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 18'd131072, 31'd1));
    send_item(make_item(32'hFFFF_FFFF, 32'h0000_0001, 31'd1, 31'd1,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'h3, 31'h7FFF_FFFF));
    send_item(make_item(32'h0000_0003, 32'h0000_0000, 31'd3, 31'd0,
                        32'd0, 32'd0, 1'b0, 1'b0, 18'h1_0000, 31'd2));
  endtask

  task automatic test_random(input int n);
    repeat (n) send_item(rand_item());
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (LATENCY + 60) send_item(rand_item());
  endtask

  task automatic test_streaming(input int n);
    idle_en = 1'b0;
    repeat (n) send_item(rand_item());
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10);
    end
    result_stall <= stall_left > 0;
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    cif_pkg::result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (expected_forces.size() == 0) begin
        $error("result with no transaction waiting: %h", result);
        errors++;
      end else begin
        exp_r = expected_forces.pop_front();
        checked_count++;
        if (result.force_one !== exp_r.force_one) begin
          $error("force_one expected %h actual %h", exp_r.force_one, result.force_one);
          errors++;
        end
        if (result.force_two !== exp_r.force_two) begin
          $error("force_two expected %h actual %h", exp_r.force_two, result.force_two);
          errors++;
        end
        if (result.status !== exp_r.status) begin
          $error("status expected %h actual %h", exp_r.status, result.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_en = 1'b1;
    test_directed();
    test_random(300);
    test_backpressure();
    test_random(100);
    test_streaming(100);
    stop_sending();
    wait (expected_forces.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d collisions (directed, random, long output hold, back-to-back stream),",
             sent_count);
    $display("checked %0d results with %0d mismatches.", checked_count, errors);
    if (errors == 0 && expected_forces.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
